@@ design/ftkil_pkg.sv @@
package ftkil_pkg;

    // list geometry
    localparam int MAX_KEEP = 16;
    localparam int IDX_W    = $clog2(MAX_KEEP);
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);

    // field widths
    localparam int TAG_W    = 16;
    localparam int WEIGHT_W = 32;
    localparam int ID_W     = 16;
    localparam int RANK_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATCH_A = 2'd0,
        CFG_MATCH_B = 2'd1,
        CFG_MATCH_C = 2'd2,
        CFG_KEEP    = 2'd3
    } t_cfg_idx;

    localparam logic [CNT_W-1:0] KEEP_RESET = CNT_W'(MAX_KEEP);

    // controller to datapath
    typedef struct packed {
        logic capture;     // take the input word
        logic insert;      // apply the captured candidate to the list
        logic emit_load;   // move the entry at the emit index to the output register
        logic clear_fill;  // list emitted, empty it
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic final_item;  // captured word ends the set
        logic fill_zero;   // list holds nothing
        logic out_free;    // output register can take a word this cycle
        logic emit_last;   // emit index points at the last held entry
    } t_dp_stat;

endpackage

@@ design/ftkil_ctrl.sv @@
module ftkil_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ftkil_pkg::t_dp_stat i_stat,
    output ftkil_pkg::t_dp_cmd  o_cmd,
    output logic                o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = i_stat.final_item ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_stat.fill_zero) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_stat.emit_last) begin
                        o_cmd.clear_fill = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ design/ftkil_dp.sv @@
module ftkil_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [ftkil_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ftkil_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input word
    input  logic [ftkil_pkg::TAG_W-1:0]          i_group_a,
    input  logic [ftkil_pkg::TAG_W-1:0]          i_group_b,
    input  logic [ftkil_pkg::TAG_W-1:0]          i_group_c,
    input  logic signed [ftkil_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [ftkil_pkg::ID_W-1:0]           i_entry_id,
    input  logic                                 i_final_item,
    // output word
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic [ftkil_pkg::RANK_W-1:0]         o_rank,
    output logic [ftkil_pkg::ID_W-1:0]           o_kept_id,
    output logic signed [ftkil_pkg::WEIGHT_W-1:0] o_kept_weight,
    output logic                                 o_last_of_run,
    // control
    input  ftkil_pkg::t_dp_cmd                   i_cmd,
    output ftkil_pkg::t_dp_stat                  o_stat
);

    localparam int N  = ftkil_pkg::MAX_KEEP;
    localparam int CW = ftkil_pkg::CNT_W;
    localparam int IW = ftkil_pkg::IDX_W;

    // configuration registers
    logic [ftkil_pkg::TAG_W-1:0] r_match_a, r_match_b, r_match_c;
    logic [CW-1:0]               r_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_a <= '0;
            r_match_b <= '0;
            r_match_c <= '0;
            r_keep    <= ftkil_pkg::KEEP_RESET;
        end else if (i_cfg_we) begin
            unique case (ftkil_pkg::t_cfg_idx'(i_cfg_index))
                ftkil_pkg::CFG_MATCH_A: r_match_a <= i_cfg_data[ftkil_pkg::TAG_W-1:0];
                ftkil_pkg::CFG_MATCH_B: r_match_b <= i_cfg_data[ftkil_pkg::TAG_W-1:0];
                ftkil_pkg::CFG_MATCH_C: r_match_c <= i_cfg_data[ftkil_pkg::TAG_W-1:0];
                ftkil_pkg::CFG_KEEP:    r_keep    <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // captured candidate
    logic                                 r_match;
    logic signed [ftkil_pkg::WEIGHT_W-1:0] r_w;
    logic [ftkil_pkg::ID_W-1:0]           r_id;
    logic                                 r_fin;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_match <= (i_group_a == r_match_a) && (i_group_b == r_match_b)
                       && (i_group_c == r_match_c);
            r_w     <= i_weight;
            r_id    <= i_entry_id;
            r_fin   <= i_final_item;
        end
    end

    // kept list
    logic signed [ftkil_pkg::WEIGHT_W-1:0] r_ent_w  [N];
    logic [ftkil_pkg::ID_W-1:0]           r_ent_id [N];
    logic [CW-1:0]                        r_fill;
    logic [IW-1:0]                        r_emit_idx;

    // effective keep count, saturated at the list depth
    logic [CW-1:0] keep_eff;
    assign keep_eff = (r_keep > CW'(N)) ? CW'(N) : r_keep;

    // per-cell compare; the list is sorted so gt_f is a run from the insert point to fill
    logic [N-1:0] gt_f;
    logic [N-1:0] hit;
    logic [N-1:0] app;
    logic         found;
    logic         can_app;

    always_comb begin
        for (int i = 0; i < N; i++) begin
            gt_f[i] = (r_w > r_ent_w[i]) && (CW'(i) < r_fill);
        end
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                hit[i] = gt_f[i] && (CW'(i) < keep_eff);
            end else begin
                hit[i] = gt_f[i] && !gt_f[i-1] && (CW'(i) < keep_eff);
            end
        end
        found   = |hit;
        can_app = !found && (r_fill < keep_eff);
        for (int i = 0; i < N; i++) begin
            app[i] = can_app && (CW'(i) == r_fill);
        end
    end

    logic do_ins;
    assign do_ins = i_cmd.insert && r_match;

    // list storage: shift behind the insert point, load at it
    always_ff @(posedge i_clk) begin
        if (do_ins) begin
            for (int i = 0; i < N; i++) begin
                if (hit[i] || app[i]) begin
                    r_ent_w[i]  <= r_w;
                    r_ent_id[i] <= r_id;
                end else if (i > 0 && found && gt_f[(i > 0) ? i-1 : 0]) begin
                    r_ent_w[i]  <= r_ent_w[(i > 0) ? i-1 : 0];
                    r_ent_id[i] <= r_ent_id[(i > 0) ? i-1 : 0];
                end
            end
        end
    end

    // fill count and emit index
    logic [CW-1:0] fill_inc;
    assign fill_inc = r_fill + CW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_emit_idx <= '0;
        end else begin
            if (i_cmd.clear_fill) begin
                r_fill     <= '0;
                r_emit_idx <= '0;
            end else begin
                if (do_ins && (can_app || (found && fill_inc <= keep_eff))) begin
                    r_fill <= fill_inc;
                end
                if (i_cmd.capture) begin
                    r_emit_idx <= '0;
                end else if (i_cmd.emit_load) begin
                    r_emit_idx <= r_emit_idx + IW'(1);
                end
            end
        end
    end

    logic emit_last;
    assign emit_last = ({1'b0, r_emit_idx} + CW'(1)) == r_fill;

    // output register
    logic out_free;
    assign out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_rank        <= ftkil_pkg::RANK_W'(r_emit_idx);
            o_kept_id     <= r_ent_id[r_emit_idx];
            o_kept_weight <= r_ent_w[r_emit_idx];
            o_last_of_run <= emit_last;
        end
    end

    // status
    assign o_stat.final_item = r_fin;
    assign o_stat.fill_zero  = (r_fill == '0);
    assign o_stat.out_free   = out_free;
    assign o_stat.emit_last  = emit_last;

endmodule

@@ design/filtered_top_k_insertion_list_unit.sv @@
// Filtered top-k insertion list.
// Input channel (i_in_valid / o_in_stall) carries one candidate word: three
// group tags, a signed Q16.16 weight, an entry id and a final flag. Only words
// whose tags equal the match registers are kept, sorted by descending weight,
// ties behind older entries, at most keep_count of them.
// Output channel (o_out_valid / i_out_stall) returns the kept list best-first
// after a final word, one word per entry, last_of_run on the last one.
// Config port: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0..2 match tags, 3 keep count); write only while the block is idle.
// Each word passes a capture step, then an insert step in which all sixteen
// cells compare in parallel; a new word is not taken before that insert.
// A final word then emits fill entries at one per cycle while the output is
// not stalled; the first result is loaded in the emit state after the insert.
// The input stalls during insert and emission. A stalled output word holds;
// emission waits on it without loss. Reset empties the list, sets the match
// tags to zero and keep count to sixteen; no clearing pass is needed.
module filtered_top_k_insertion_list_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ftkil_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ftkil_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [ftkil_pkg::TAG_W-1:0]          i_group_a,
    input  logic [ftkil_pkg::TAG_W-1:0]          i_group_b,
    input  logic [ftkil_pkg::TAG_W-1:0]          i_group_c,
    input  logic signed [ftkil_pkg::WEIGHT_W-1:0] i_weight,
    input  logic [ftkil_pkg::ID_W-1:0]           i_entry_id,
    input  logic                                 i_final_item,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [ftkil_pkg::RANK_W-1:0]         o_rank,
    output logic [ftkil_pkg::ID_W-1:0]           o_kept_id,
    output logic signed [ftkil_pkg::WEIGHT_W-1:0] o_kept_weight,
    output logic                                 o_last_of_run
);

    ftkil_pkg::t_dp_cmd  cmd;
    ftkil_pkg::t_dp_stat stat;

    // sequencing
    ftkil_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // list storage, compare row and output register
    ftkil_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_group_a     (i_group_a),
        .i_group_b     (i_group_b),
        .i_group_c     (i_group_c),
        .i_weight      (i_weight),
        .i_entry_id    (i_entry_id),
        .i_final_item  (i_final_item),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_rank        (o_rank),
        .o_kept_id     (o_kept_id),
        .o_kept_weight (o_kept_weight),
        .o_last_of_run (o_last_of_run),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

endmodule

@@ tb/filtered_top_k_insertion_list_unit_tb.sv @@
module filtered_top_k_insertion_list_unit_tb;

    localparam int MAX_KEEP   = ftkil_pkg::MAX_KEEP;
    localparam int CNT_W      = ftkil_pkg::CNT_W;
    localparam int TAG_W      = ftkil_pkg::TAG_W;
    localparam int WEIGHT_W   = ftkil_pkg::WEIGHT_W;
    localparam int ID_W       = ftkil_pkg::ID_W;
    localparam int RANK_W     = ftkil_pkg::RANK_W;
    localparam int CFG_IDX_W  = ftkil_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ftkil_pkg::CFG_DATA_W;

    localparam int QUIET_LIMIT    = 2000;  // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES  = 8;     // covers the insert cycle of a last non-final word
    localparam int RANDOM_MATCHED = 168;   // tag-matching candidates in the random part
    localparam int SUB_PHASES     = 4;     // register settings per idling mode
    localparam int EMIT_MAX       = 1 << RANK_W;

    // one ranked word of an emitted list
    typedef struct {
        logic [RANK_W-1:0]          rank;
        logic [ID_W-1:0]            kept_id;
        logic signed [WEIGHT_W-1:0] kept_weight;
        logic                       last_of_run;
    } t_ranked_word;

    // Tracks the kept list and the ranked words still owed by the block.
    class t_topk_scoreboard;
        logic [TAG_W-1:0]           want_a = '0;
        logic [TAG_W-1:0]           want_b = '0;
        logic [TAG_W-1:0]           want_c = '0;
        logic [CNT_W-1:0]           keep_reg = ftkil_pkg::KEEP_RESET;
        logic signed [WEIGHT_W-1:0] list_w [MAX_KEEP];
        logic [ID_W-1:0]            list_id [MAX_KEEP];
        int                         fill = 0;
        t_ranked_word               due_words[$];
        int                         mismatches = 0;
        int                         words_seen = 0;
        int                         lists_emitted = 0;
        int                         considered = 0;

        function void write_reg(ftkil_pkg::t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                ftkil_pkg::CFG_MATCH_A: want_a = data;
                ftkil_pkg::CFG_MATCH_B: want_b = data;
                ftkil_pkg::CFG_MATCH_C: want_c = data;
                ftkil_pkg::CFG_KEEP:    keep_reg = data[CNT_W-1:0];
                default:                ;
            endcase
        endfunction

        // Apply one accepted candidate; a final word queues the whole list.
        function void note_word(logic [TAG_W-1:0] ga, logic [TAG_W-1:0] gb,
                                logic [TAG_W-1:0] gc, logic signed [WEIGHT_W-1:0] w,
                                logic [ID_W-1:0] id, logic fin);
            int           k;
            int           i;
            int           j;
            int           n;
            bit           placed;
            t_ranked_word rw;
            if (ga == want_a && gb == want_b && gc == want_c) begin
                considered++;
                k = (keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg);
                placed = 0;
                // only the first k entries are compared; ties stay behind
                for (i = 0; i < k && !placed; i++) begin
                    if (i >= fill) begin
                        list_w[i] = w;
                        list_id[i] = id;
                        fill = i + 1;
                        placed = 1;
                    end else if (w > list_w[i]) begin
                        j = (fill < MAX_KEEP) ? fill : MAX_KEEP - 1;
                        while (j > i) begin
                            list_w[j] = list_w[j-1];
                            list_id[j] = list_id[j-1];
                            j--;
                        end
                        list_w[i] = w;
                        list_id[i] = id;
                        // held count never grows past keep, lowest falls off
                        if (fill < k)
                            fill++;
                        placed = 1;
                    end
                end
            end
            if (fin) begin
                n = (fill < EMIT_MAX) ? fill : EMIT_MAX;
                for (i = 0; i < n; i++) begin
                    rw.rank = RANK_W'(i);
                    rw.kept_id = list_id[i];
                    rw.kept_weight = list_w[i];
                    rw.last_of_run = (i == n - 1);
                    due_words = {due_words, rw};
                end
                if (n > 0)
                    lists_emitted++;
                fill = 0;
            end
        endfunction

        // Compare one accepted result word against the oldest one owed.
        function void check_word(logic [RANK_W-1:0] rank, logic [ID_W-1:0] id,
                                 logic signed [WEIGHT_W-1:0] w, logic last);
            t_ranked_word owed;
            words_seen++;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: rank %0d id %h weight %h last %b",
                             rank, id, w, last);
                return;
            end
            owed = due_words.pop_front();
            if (owed.rank !== rank || owed.kept_id !== id ||
                owed.kept_weight !== w || owed.last_of_run !== last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("word mismatch: expected rank %0d id %h weight %h last %b",
                             owed.rank, owed.kept_id, owed.kept_weight, owed.last_of_run);
                    $display("               got      rank %0d id %h weight %h last %b",
                             rank, id, w, last);
                end
            end
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [TAG_W-1:0]           i_group_a = '0;
    logic [TAG_W-1:0]           i_group_b = '0;
    logic [TAG_W-1:0]           i_group_c = '0;
    logic signed [WEIGHT_W-1:0] i_weight = '0;
    logic [ID_W-1:0]            i_entry_id = '0;
    logic                       i_final_item = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [RANK_W-1:0]          o_rank;
    logic [ID_W-1:0]            o_kept_id;
    logic signed [WEIGHT_W-1:0] o_kept_weight;
    logic                       o_last_of_run;

    t_topk_scoreboard sb = new;
    int send_idle_pct = 23;
    int recv_idle_pct = 70;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int words_offered = 0;
    int cfg_writes = 0;

    filtered_top_k_insertion_list_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_group_a     (i_group_a),
        .i_group_b     (i_group_b),
        .i_group_c     (i_group_c),
        .i_weight      (i_weight),
        .i_entry_id    (i_entry_id),
        .i_final_item  (i_final_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rank        (o_rank),
        .o_kept_id     (o_kept_id),
        .o_kept_weight (o_kept_weight),
        .o_last_of_run (o_last_of_run)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: check accepted words, then pick next stall (long hold-off wins)
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(o_rank, o_kept_id, o_kept_weight, o_last_of_run);
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // offer one candidate word, hold it until accepted
    task automatic offer_word(input logic [TAG_W-1:0] ga, input logic [TAG_W-1:0] gb,
                              input logic [TAG_W-1:0] gc,
                              input logic signed [WEIGHT_W-1:0] w,
                              input logic [ID_W-1:0] id, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_group_a    <= ga;
        i_group_b    <= gb;
        i_group_c    <= gc;
        i_weight     <= w;
        i_entry_id   <= id;
        i_final_item <= fin;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_word(ga, gb, gc, w, id, fin);
        words_offered++;
    endtask

    // register write once the block has drained
    task automatic write_reg(input ftkil_pkg::t_cfg_idx idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (sb.due_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [TAG_W-1:0] pick_tag();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return TAG_W'($urandom);
        endcase
    endfunction

    // extremes, tie-prone whole numbers, or anything
    function automatic logic signed [WEIGHT_W-1:0] pick_weight();
        int step;
        step = int'($urandom_range(6)) - 3;
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3, 4: return step <<< 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_keep();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CNT_W'(1);
            2:       return CNT_W'(MAX_KEEP);
            3:       return CNT_W'($urandom_range(MAX_KEEP + 1, (1 << CNT_W) - 1));
            default: return CNT_W'($urandom_range(1, MAX_KEEP));
        endcase
    endfunction

    // one set of candidates, closed by a final word when asked
    task automatic send_set(input int len, input bit close, input int match_pct);
        logic [TAG_W-1:0] ga;
        logic [TAG_W-1:0] gb;
        logic [TAG_W-1:0] gc;
        int               n;
        for (n = 0; n < len; n++) begin
            ga = sb.want_a;
            gb = sb.want_b;
            gc = sb.want_c;
            if ($urandom_range(99) >= match_pct) begin
                // miss on all tags, or by a single bit in one tag
                case ($urandom_range(3))
                    0: begin
                        ga = TAG_W'($urandom);
                        gb = TAG_W'($urandom);
                        gc = TAG_W'($urandom);
                    end
                    1: ga = ga ^ (TAG_W'(1) << $urandom_range(TAG_W - 1));
                    2: gb = gb ^ (TAG_W'(1) << $urandom_range(TAG_W - 1));
                    default: gc = gc ^ (TAG_W'(1) << $urandom_range(TAG_W - 1));
                endcase
            end
            offer_word(ga, gb, gc, pick_weight(), ID_W'($urandom),
                       close && (n == len - 1));
        end
    endtask

    initial begin
        int mode;
        int sub;
        int goal;
        bit pressure;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // final word on an empty list emits nothing
        offer_word(16'h0001, 16'h0000, 16'h0000, 32'sh0000_0100, 16'h00AA, 1'b0 | 1'b1);
        // reset tags: weight extremes, ties, tag misses on each tag, final tie at bottom
        offer_word(16'h0000, 16'h0000, 16'h0000, 32'sh7FFF_FFFF, 16'hFFFF, 1'b0);
        offer_word(16'h0000, 16'h0000, 16'h0000, 32'sh8000_0000, 16'h0000, 1'b0);
        offer_word(16'h0000, 16'h0000, 16'h0000, 32'sh0000_0000, 16'h0001, 1'b0);
        offer_word(16'h0000, 16'h0000, 16'h0000, 32'sh0000_0000, 16'h0002, 1'b0);
        offer_word(16'h0000, 16'h0000, 16'h0000, 32'sh0001_0000, 16'h0003, 1'b0);
        offer_word(16'hFFFF, 16'h0000, 16'h0000, 32'sh7FFF_FFFF, 16'h0BAD, 1'b0);
        offer_word(16'h0000, 16'h8000, 16'h0000, 32'sh7FFF_FFFF, 16'h0BAD, 1'b0);
        offer_word(16'h0000, 16'h0000, 16'h0001, 32'sh7FFF_FFFF, 16'h0BAD, 1'b0);
        offer_word(16'h0000, 16'h0000, 16'h0000, 32'sh8000_0000, 16'h0004, 1'b1);

        // keep one: only the best stays, a tie does not displace it
        write_reg(ftkil_pkg::CFG_MATCH_A, 16'hFFFF);
        write_reg(ftkil_pkg::CFG_MATCH_B, 16'hFFFF);
        write_reg(ftkil_pkg::CFG_MATCH_C, 16'hFFFF);
        write_reg(ftkil_pkg::CFG_KEEP, 16'd1);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0000_000A, 16'h0005, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0000_0014, 16'h0006, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0000_0014, 16'h0007, 1'b0);
        offer_word(16'h7FFF, 16'hFFFF, 16'hFFFF, 32'sh7FFF_FFFF, 16'h0008, 1'b1);

        // keep zero holds nothing
        write_reg(ftkil_pkg::CFG_KEEP, 16'd0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0000_0001, 16'h0009, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0000_0002, 16'h000A, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0000_0003, 16'h000B, 1'b1);

        // keep above the list size saturates, then lowered with entries held
        write_reg(ftkil_pkg::CFG_KEEP, 16'd31);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0001_0000, 16'h0010, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0002_0000, 16'h0011, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0003_0000, 16'h0012, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0004_0000, 16'h0013, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0005_0000, 16'h0014, 1'b0);
        write_reg(ftkil_pkg::CFG_KEEP, 16'd2);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0003_8000, 16'h0015, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh000A_0000, 16'h0016, 1'b0);
        offer_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'sh0004_8000, 16'h0017, 1'b1);

        // random sets over three idling modes, several settings each
        for (mode = 0; mode < 3; mode++) begin
            for (sub = 0; sub < SUB_PHASES; sub++) begin
                pressure = (mode == 2 && sub == 0);
                write_reg(ftkil_pkg::CFG_MATCH_A, pick_tag());
                write_reg(ftkil_pkg::CFG_MATCH_B, pick_tag());
                write_reg(ftkil_pkg::CFG_MATCH_C, pick_tag());
                write_reg(ftkil_pkg::CFG_KEEP, pressure ? CFG_DATA_W'(MAX_KEEP) :
                                                          CFG_DATA_W'(pick_keep()));
                if (sub == 0) begin
                    case (mode)
                        0: begin
                            send_idle_pct = 23;
                            recv_idle_pct = 70;
                        end
                        1: begin
                            send_idle_pct = 70;
                            recv_idle_pct = 23;
                        end
                        default: begin
                            send_idle_pct = 0;
                            recv_idle_pct = 0;
                        end
                    endcase
                end
                goal = sb.considered + RANDOM_MATCHED / (3 * SUB_PHASES);
                // output held off while a full list goes out and more words wait
                if (pressure) begin
                    hold_request = 200;
                    send_set(20, 1'b1, 100);
                    send_set(6, 1'b0, 100);
                end
                while (sb.considered < goal)
                    send_set($urandom_range(1, 20), $urandom_range(3) != 0, 85);
            end
        end
        i_in_valid <= 1'b0;

        // drain, then let the block settle
        while (sb.due_words.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("covered %0d candidate words (%0d matching tags) under %0d register writes",
                 words_offered, sb.considered, cfg_writes);
        $display("%0d lists emitted, %0d result words checked, %0d mismatches, %0d owed",
                 sb.lists_emitted, sb.words_seen, sb.mismatches, sb.due_words.size());
        if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/ftkil_pkg.sv
design/ftkil_ctrl.sv
design/ftkil_dp.sv
design/filtered_top_k_insertion_list_unit.sv
tb/filtered_top_k_insertion_list_unit_tb.sv
